// ----- src/band_reciprocal_pivot_growth_defines.svh -----
// ----------------------------------------------------------------------------
// band_reciprocal_pivot_growth_defines.svh
// Assertion macros used by the pivot growth back end.
// ----------------------------------------------------------------------------
`ifndef BAND_RECIPROCAL_PIVOT_GROWTH_DEFINES_SVH
`define BAND_RECIPROCAL_PIVOT_GROWTH_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define BRPG_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("brpg: implication check failed");

// Next-cycle implication, clocked on clk, off during rst.
`define BRPG_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("brpg: next-cycle check failed");

`endif

// ----- src/brpg_pkg.sv -----
// ----------------------------------------------------------------------------
// brpg_pkg
// Types and constants of the band reciprocal pivot growth block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brpg_pkg;

  localparam int MAX_ORDER_DEF = 4096;
  localparam int QUEUE_DEPTH   = 4;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 13;

  localparam logic [16:0] RATIO_ONE = 17'd65536;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MATRIX_ORDER    = 2'd0,
    REG_SUB_DIAGONALS   = 2'd1,
    REG_SUPER_DIAGONALS = 2'd2,
    REG_COLUMNS_USED    = 2'd3
  } brpg_reg_t;

  // clamped configuration as seen by the front end
  typedef struct packed {
    logic [12:0] order;
    logic [11:0] kl;
    logic [11:0] ku;
    logic [12:0] cols;
  } brpg_cfg_t;

  // one closed column, front end to back end
  typedef struct packed {
    logic [16:0] amax;
    logic [16:0] umax;
    logic        live;
    logic        mat_end;
  } brpg_col_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } brpg_state_t;

endpackage

// ----- src/brpg_elem_if.sv -----
// ----------------------------------------------------------------------------
// brpg_elem_if
// Element channel: one tagged complex matrix element per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface brpg_elem_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [11:0]        row_index;
  logic [11:0]        col_index;
  logic signed [15:0] elem_real;
  logic signed [15:0] elem_imag;
  logic               column_end;
  logic               matrix_end;

  modport source (
    output valid, op, row_index, col_index, elem_real, elem_imag, column_end, matrix_end,
    input  ready
  );
  modport sink (
    input  valid, op, row_index, col_index, elem_real, elem_imag, column_end, matrix_end,
    output ready
  );
endinterface

// ----- src/brpg_ratio_if.sv -----
// ----------------------------------------------------------------------------
// brpg_ratio_if
// Result channel: one growth ratio per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface brpg_ratio_if;
  logic        valid;
  logic        ready;
  logic [16:0] growth_ratio;

  modport source (output valid, growth_ratio, input ready);
  modport sink (input valid, growth_ratio, output ready);
endinterface

// ----- src/band_reciprocal_pivot_growth.sv -----
// ----------------------------------------------------------------------------
// band_reciprocal_pivot_growth
// Reciprocal pivot growth of a banded complex LU factorization, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   elem carries one matrix element per transfer, tagged A or U, with row,
//   column and end-of-column / end-of-matrix marks. ratio carries one Q1.16
//   growth ratio after each end-of-matrix element. The configuration port
//   (cfg_write, cfg_index, cfg_data) is to be written only while the block
//   is idle; this is not enforced. Throughput: one element per cycle. Each
//   column close is queued (four entries) and passes the back end's idle
//   and emit states, plus its divide and apply states when a quotient is
//   needed: the divider yields one quotient bit per cycle. The element
//   channel stalls only while the column queue is full. The result is
//   registered as the end-of-matrix column leaves the back end.
//   Reset clears the configuration to zero, the column maxima to zero and
//   the running ratio to 1.0. A stalled result is held in its output
//   register; the front end keeps taking elements until the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module band_reciprocal_pivot_growth #(
  parameter int MAX_ORDER = brpg_pkg::MAX_ORDER_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [brpg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [brpg_pkg::CFG_DATA_W-1:0]  cfg_data,
  brpg_elem_if.sink                        elem,
  brpg_ratio_if.source                     ratio
);

  localparam logic [16:0] MaxOrd = 17'(MAX_ORDER);

  logic [12:0]         matrix_order;
  logic [11:0]         sub_diagonals;
  logic [11:0]         super_diagonals;
  logic [12:0]         columns_used;
  brpg_pkg::brpg_cfg_t cfg;

  logic                q_full;
  logic                q_push;
  brpg_pkg::brpg_col_t q_in;
  logic                q_pop;
  logic                q_avail;
  brpg_pkg::brpg_col_t q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_order    <= '0;
      sub_diagonals   <= '0;
      super_diagonals <= '0;
      columns_used    <= '0;
    end else if (cfg_write) begin
      unique case (brpg_pkg::brpg_reg_t'(cfg_index))
        brpg_pkg::REG_MATRIX_ORDER:    matrix_order    <= cfg_data;
        brpg_pkg::REG_SUB_DIAGONALS:   sub_diagonals   <= cfg_data[11:0];
        brpg_pkg::REG_SUPER_DIAGONALS: super_diagonals <= cfg_data[11:0];
        brpg_pkg::REG_COLUMNS_USED:    columns_used    <= cfg_data;
        default: ;
      endcase
    end
  end

  // order and column count saturate at MAX_ORDER
  assign cfg.order = ({4'd0, matrix_order} > MaxOrd) ? MaxOrd[12:0] : matrix_order;
  assign cfg.cols  = ({4'd0, columns_used} > MaxOrd) ? MaxOrd[12:0] : columns_used;
  assign cfg.kl    = sub_diagonals;
  assign cfg.ku    = super_diagonals;

  brpg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .elem   (elem),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  brpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_out)
  );

  brpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_avail   (q_avail),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .ratio_out (ratio)
  );

endmodule

// ----- src/brpg_front.sv -----
// ----------------------------------------------------------------------------
// brpg_front
// Accepts elements, keeps per-column A and U maxima, hands closed columns
// to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brpg_front (
  input  logic                clk,
  input  logic                rst,
  input  brpg_pkg::brpg_cfg_t cfg,
  brpg_elem_if.sink           elem,
  input  logic                q_full,
  output logic                q_push,
  output brpg_pkg::brpg_col_t q_data
);

  logic [16:0] a_max;
  logic [16:0] u_max;
  logic [16:0] mag_re;
  logic [16:0] mag_im;
  logic [16:0] mag;
  logic [12:0] i13;
  logic [12:0] j13;
  logic        col_live;
  logic        above_top;
  logic        a_hit;
  logic        u_hit;
  logic [16:0] a_next;
  logic [16:0] u_next;
  logic        take;
  logic        close;

  assign mag_re = elem.elem_real[15] ? 17'(~{1'b1, elem.elem_real} + 17'd1)
                                     : {1'b0, elem.elem_real};
  assign mag_im = elem.elem_imag[15] ? 17'(~{1'b1, elem.elem_imag} + 17'd1)
                                     : {1'b0, elem.elem_imag};
  assign mag    = mag_re + mag_im;

  assign i13       = {1'b0, elem.row_index};
  assign j13       = {1'b0, elem.col_index};
  assign col_live  = j13 < cfg.cols;
  assign above_top = (i13 + {1'b0, cfg.ku}) >= j13;

  assign a_hit = col_live && above_top && !elem.op && (i13 <= j13 + {1'b0, cfg.kl})
                 && (i13 < cfg.order) && (mag > a_max);
  assign u_hit = col_live && above_top && elem.op && (i13 <= j13) && (mag > u_max);

  assign a_next = a_hit ? mag : a_max;
  assign u_next = u_hit ? mag : u_max;

  assign elem.ready = !q_full;
  assign take       = elem.valid && elem.ready;
  assign close      = elem.column_end || elem.matrix_end;

  assign q_push         = take && close;
  assign q_data.amax    = a_next;
  assign q_data.umax    = u_next;
  assign q_data.live    = col_live;
  assign q_data.mat_end = elem.matrix_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_max <= '0;
      u_max <= '0;
    end else if (take) begin
      if (close) begin
        a_max <= '0;
        u_max <= '0;
      end else begin
        a_max <= a_next;
        u_max <= u_next;
      end
    end
  end

endmodule

// ----- src/brpg_queue.sv -----
// ----------------------------------------------------------------------------
// brpg_queue
// Short register FIFO of closed columns between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brpg_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  brpg_pkg::brpg_col_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                avail,
  output brpg_pkg::brpg_col_t pop_data
);

  localparam int Depth = brpg_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);

  brpg_pkg::brpg_col_t slots [Depth];
  logic [PtrW-1:0]     wptr;
  logic [PtrW-1:0]     rptr;
  logic [PtrW:0]       count;
  logic                do_push;
  logic                do_pop;

  assign full     = count == (PtrW+1)'(Depth);
  assign avail    = count != '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/brpg_back.sv -----
// ----------------------------------------------------------------------------
// brpg_back
// Per-column quotient amax/umax, one quotient bit a cycle, running minimum
// and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "band_reciprocal_pivot_growth_defines.svh"

module brpg_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_avail,
  input  brpg_pkg::brpg_col_t q_data,
  output logic                q_pop,
  brpg_ratio_if.source        ratio_out
);

  brpg_pkg::brpg_state_t state;
  brpg_pkg::brpg_state_t state_next;

  logic [16:0] ratio;
  logic [16:0] umax_r;
  logic        mat_end_r;
  logic [16:0] rem;
  logic [15:0] quo;
  logic [3:0]  step;
  logic [16:0] out_ratio;
  logic        out_valid;

  logic        need_div;
  logic        out_free;
  logic        load_out;
  logic        div_last;
  logic [17:0] trial;
  logic        ge;

  assign need_div = q_data.live && (q_data.umax != '0) && (q_data.amax < q_data.umax);
  assign out_free = !out_valid || ratio_out.ready;
  assign trial    = {rem, 1'b0};
  assign ge       = trial >= {1'b0, umax_r};
  assign div_last = step == 4'd15;

  always_comb begin
    state_next = state;
    unique case (state)
      brpg_pkg::ST_IDLE: begin
        if (q_avail) begin
          state_next = need_div ? brpg_pkg::ST_DIV : brpg_pkg::ST_EMIT;
        end
      end
      brpg_pkg::ST_DIV: begin
        if (div_last) begin
          state_next = brpg_pkg::ST_APPLY;
        end
      end
      brpg_pkg::ST_APPLY: state_next = brpg_pkg::ST_EMIT;
      brpg_pkg::ST_EMIT: begin
        if (!mat_end_r || out_free) begin
          state_next = brpg_pkg::ST_IDLE;
        end
      end
      default: state_next = brpg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      brpg_pkg::ST_IDLE:  q_pop = q_avail;
      brpg_pkg::ST_DIV:   ;
      brpg_pkg::ST_APPLY: ;
      brpg_pkg::ST_EMIT:  load_out = mat_end_r && out_free;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brpg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      umax_r    <= q_data.umax;
      mat_end_r <= q_data.mat_end;
      rem       <= q_data.amax;
      quo       <= '0;
      step      <= '0;
    end else if (state == brpg_pkg::ST_DIV) begin
      rem  <= ge ? 17'(trial - {1'b0, umax_r}) : trial[16:0];
      quo  <= {quo[14:0], ge};
      step <= step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= brpg_pkg::RATIO_ONE;
    end else if (load_out) begin
      ratio <= brpg_pkg::RATIO_ONE;
    end else if (state == brpg_pkg::ST_APPLY && {1'b0, quo} < ratio) begin
      ratio <= {1'b0, quo};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (ratio_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ratio <= ratio;
    end
  end

  assign ratio_out.valid        = out_valid;
  assign ratio_out.growth_ratio = out_ratio;

  `BRPG_ASSERT_IMPL(a_div_nonzero, state == brpg_pkg::ST_DIV, umax_r != '0)
  `BRPG_ASSERT_IMPL(a_ratio_bound, 1'b1, ratio <= brpg_pkg::RATIO_ONE)
  `BRPG_ASSERT_IMPL(a_load_free, load_out, !out_valid || ratio_out.ready)
  `BRPG_ASSERT_NEXT(a_emit_rearm, load_out, ratio == brpg_pkg::RATIO_ONE && out_valid)

endmodule
